// ----- hw/rtl/sector_cache_clock_controller_core_assert.svh -----
// Assertion macros for the sector cache clock controller.
`ifndef SECTOR_CACHE_CLOCK_CONTROLLER_CORE_ASSERT_SVH
`define SECTOR_CACHE_CLOCK_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCC_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCC_ASSERT(label, clk, rst_n, prop, msg)
`define SCC_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the sector cache clock controller.
// ----------------------------------------------------------------------------
`default_nettype none
package scc_pkg;
    localparam int SlotsDefault = 64;
    localparam int MaxOut       = 64;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_FLUSH = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK,
        ST_FLUSH,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- hw/rtl/scc_tag_store.sv -----
// ----------------------------------------------------------------------------
// scc_tag_store
// Slot state: tags, owners in memories; status bits in flops. One slot
// read port (registered) and one write port, plus a parallel tag match and free-slot search.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sector_cache_clock_controller_core_assert.svh"
module scc_tag_store
    import scc_pkg::*;
#(
    parameter int SLOTS = SlotsDefault,
    localparam int AW = $clog2(SLOTS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [2:0]    i_dev,
    input  wire logic [31:0]   i_sec,
    output logic               o_hit,
    output logic [AW-1:0]      o_hit_slot,
    output logic               o_free,
    output logic [AW-1:0]      o_free_slot,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [2:0]         o_rd_dev,
    output logic [31:0]        o_rd_sec,
    output logic [15:0]        o_rd_owner,
    output logic               o_rd_dirty,
    output logic               o_rd_acc,
    input  wire logic          i_tag_we,
    input  wire logic          i_clr,
    input  wire logic          i_acc_clr,
    input  wire logic          i_touch,
    input  wire logic          i_set_dirty,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [15:0]   i_wr_owner
);
    logic [2:0]       r_tdev [SLOTS];
    logic [31:0]      r_tsec [SLOTS];
    logic [15:0]      r_own  [SLOTS];
    logic [SLOTS-1:0] r_valid, r_used, r_acc, r_dirty;

    always_ff @(posedge i_clk) begin
        if (i_tag_we) begin
            r_tdev[i_wr_addr] <= i_dev;
            r_tsec[i_wr_addr] <= i_sec;
        end
        if (i_touch) begin
            r_own[i_wr_addr] <= i_wr_owner;
        end else if (i_clr) begin
            r_own[i_wr_addr] <= 16'd0;
        end
        o_rd_dev   <= r_tdev[i_rd_addr];
        o_rd_sec   <= r_tsec[i_rd_addr];
        o_rd_owner <= r_used[i_rd_addr] ? r_own[i_rd_addr] : 16'd0;
        o_rd_dirty <= r_dirty[i_rd_addr];
        o_rd_acc   <= r_acc[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            r_acc   <= '0;
            r_dirty <= '0;
        end else begin
            if (i_clr) begin
                r_valid[i_wr_addr] <= 1'b0;
                r_acc[i_wr_addr]   <= 1'b0;
                r_dirty[i_wr_addr] <= 1'b0;
            end
            if (i_acc_clr) begin
                r_acc[i_wr_addr] <= 1'b0;
            end
            if (i_tag_we) begin
                r_valid[i_wr_addr] <= 1'b1;
                r_used[i_wr_addr]  <= 1'b1;
            end
            if (i_touch) begin
                r_acc[i_wr_addr] <= 1'b1;
                if (i_set_dirty) begin
                    r_dirty[i_wr_addr] <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_hit       = 1'b0;
        o_hit_slot  = '0;
        o_free      = 1'b0;
        o_free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_tdev[i] == i_dev && r_tsec[i] == i_sec) begin
                o_hit      = 1'b1;
                o_hit_slot = AW'(i);
            end
            if (!r_used[i]) begin
                o_free      = 1'b1;
                o_free_slot = AW'(i);
            end
        end
    end

    `SCC_ASSERT(a_valid_used, i_clk, i_rst_n, (r_valid & ~r_used) == '0,
        "valid slot never marked used")
    `SCC_ASSERT(a_dirty_valid, i_clk, i_rst_n, (r_dirty & ~r_valid) == '0,
        "dirty slot not valid")
    `SCC_ASSERT(a_one_op, i_clk, i_rst_n, !(i_clr && i_touch && !i_tag_we),
        "clear and touch without refill")
endmodule
`default_nettype wire

// ----- hw/rtl/sector_cache_clock_controller_core.sv -----
// ----------------------------------------------------------------------------
// sector_cache_clock_controller_core
// Tag and replacement control for a fully associative write-back cache.
// ----------------------------------------------------------------------------
// Usage: one request channel (i_valid/o_stall, func, device, sector, owner)
// and one result channel (o_valid/i_stall). o_stall is high while a request
// is in work; one request is handled at a time.
// Read/write: one result. A hit, or a miss with a never-used slot, is resolved
// in ST_LOOKUP, which waits while the result register is held, and then
// returns to idle for the next request. A clock walk examines up to SLOTS+1
// slots, one at a time, on the single slot read port of the store.
// Flush: a sweep of all slots, each slot read and then updated; a flush with
// no dirty match gives no result.
// The result register holds its value while i_stall is high and the
// sequencer waits. Reset clears all slot status bits and the hand at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sector_cache_clock_controller_core_assert.svh"
module sector_cache_clock_controller_core
    import scc_pkg::*;
#(
    parameter int SLOTS = SlotsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [2:0]  i_device,
    input  wire logic [31:0] i_sector,
    input  wire logic [15:0] i_owner,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_slot,
    output logic             o_hit,
    output logic             o_fetch,
    output logic             o_write_back,
    output logic [2:0]       o_wb_device,
    output logic [31:0]      o_wb_sector,
    output logic             o_last
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(MaxOut + 1);

    t_state r_state, n_state;
    t_func r_func;
    logic [2:0] r_dev;
    logic [31:0] r_sec;
    logic [15:0] r_own;
    logic [AW-1:0] r_hand, r_ptr, n_ptr;
    logic r_phase;
    logic [CW-1:0] r_cnt;
    logic r_pend;
    logic [AW-1:0] r_pslot;
    logic [2:0] r_pdev;
    logic [31:0] r_psec;

    logic hit, free;
    logic [AW-1:0] hit_slot, free_slot, rd_addr, wr_addr;
    logic [2:0] rd_dev;
    logic [31:0] rd_sec;
    logic [15:0] rd_owner;
    logic rd_dirty, rd_acc;
    logic tag_we, clr, acc_clr, touch;

    logic [AW-1:0] hand_nx;
    logic accept, out_free, last_slot, match;
    logic flush_rel, phase_hold;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign out_free = !o_valid || !i_stall;
    assign hand_nx  = (r_hand == AW'(SLOTS - 1)) ? '0 : r_hand + 1'b1;
    assign last_slot = (r_ptr == AW'(SLOTS - 1));
    assign match    = (rd_owner == r_own);
    assign rd_addr  = (r_state == ST_WALK) ? (r_phase ? r_hand : hand_nx) : r_ptr;

    // next dirty match found: the held flush result is not the last one
    assign flush_rel = (r_state == ST_FLUSH) && r_phase && r_pend && match
        && rd_dirty && r_cnt != CW'(MaxOut);
    assign phase_hold = r_phase && ((r_state == ST_WALK && !rd_acc) || flush_rel);

    scc_tag_store #(.SLOTS(SLOTS)) u_store (
        .i_clk, .i_rst_n,
        .i_dev(r_dev), .i_sec(r_sec),
        .o_hit(hit), .o_hit_slot(hit_slot),
        .o_free(free), .o_free_slot(free_slot),
        .i_rd_addr(rd_addr),
        .o_rd_dev(rd_dev), .o_rd_sec(rd_sec), .o_rd_owner(rd_owner),
        .o_rd_dirty(rd_dirty), .o_rd_acc(rd_acc),
        .i_tag_we(tag_we), .i_clr(clr), .i_acc_clr(acc_clr),
        .i_touch(touch), .i_set_dirty(r_func == FUNC_WRITE),
        .i_wr_addr(wr_addr), .i_wr_owner(r_own)
    );

    // Flush emits go through r_pend, a one-deep holding slot to the output.
    logic out_load;
    logic [5:0] out_slot;
    logic out_hit, out_fetch, out_wb, out_last;
    logic [2:0] out_dev;
    logic [31:0] out_sec;

    always_comb begin
        n_state  = r_state;
        tag_we   = 1'b0;
        clr      = 1'b0;
        acc_clr  = 1'b0;
        touch    = 1'b0;
        wr_addr  = r_ptr;
        n_ptr    = r_ptr;
        out_load = 1'b0;
        out_slot = '0;
        out_hit  = 1'b0;
        out_fetch = 1'b0;
        out_wb   = 1'b0;
        out_dev  = '0;
        out_sec  = '0;
        out_last = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_func'(i_func))
                        FUNC_FLUSH: n_state = ST_FLUSH;
                        FUNC_NONE:  n_state = ST_IDLE;
                        default:    n_state = ST_LOOKUP;
                    endcase
                    n_ptr = '0;
                end
            end
            ST_LOOKUP: begin
                if (hit || free) begin
                    if (out_free) begin
                        wr_addr  = hit ? hit_slot : free_slot;
                        tag_we   = !hit;
                        touch    = 1'b1;
                        out_load = 1'b1;
                        out_slot = 6'(wr_addr);
                        out_hit  = hit;
                        out_fetch = !hit;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                wr_addr = r_hand;
                if (r_phase) begin
                    if (rd_acc) begin
                        acc_clr = 1'b1;
                    end else if (out_free) begin
                        clr      = 1'b1;
                        tag_we   = 1'b1;
                        touch    = 1'b1;
                        out_load = 1'b1;
                        out_slot = 6'(r_hand);
                        out_fetch = 1'b1;
                        out_wb   = rd_dirty;
                        out_dev  = rd_dirty ? rd_dev : 3'd0;
                        out_sec  = rd_dirty ? rd_sec : 32'd0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                wr_addr = r_ptr;
                if (r_phase) begin
                    if (match && rd_dirty && r_cnt == CW'(MaxOut)) begin
                        n_state = ST_OUT;
                    end else if (!(match && rd_dirty && r_pend)) begin
                        if (match) clr = 1'b1;
                        if (last_slot) n_state = ST_OUT;
                        else n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (!r_pend) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_pend && out_free && (flush_rel || r_state == ST_OUT)) begin
            out_load = 1'b1;
            out_slot = 6'(r_pslot);
            out_wb   = 1'b1;
            out_dev  = r_pdev;
            out_sec  = r_psec;
            // last when no more flush results can follow
            out_last = (r_state == ST_OUT);
        end
    end

    // Phase and flush bookkeeping. A pending flush result is released only
    // once the next dirty match (or the end) is known.
    logic flush_emit;
    assign flush_emit = (r_state == ST_FLUSH) && r_phase && !r_pend && match
        && rd_dirty && r_cnt != CW'(MaxOut);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hand  <= '0;
            r_phase <= 1'b0;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_ptr   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            if (r_state == ST_WALK || r_state == ST_FLUSH) begin
                if (!phase_hold) begin
                    r_phase <= !r_phase;
                end
            end else begin
                r_phase <= 1'b0;
            end
            if (r_state == ST_WALK && !r_phase) r_hand <= hand_nx;
            if (accept) r_cnt <= '0;
            if (out_load && r_pend) begin
                r_pend <= 1'b0;
            end
            if (flush_emit) begin
                r_pend  <= 1'b1;
                r_cnt   <= r_cnt + 1'b1;
                r_pslot <= r_ptr;
                r_pdev  <= rd_dev;
                r_psec  <= rd_sec;
            end
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_func);
            r_dev  <= i_device;
            r_sec  <= i_sector;
            r_own  <= i_owner;
        end
        if (out_load) begin
            o_slot       <= out_slot;
            o_hit        <= out_hit;
            o_fetch      <= out_fetch;
            o_write_back <= out_wb;
            o_wb_device  <= out_dev;
            o_wb_sector  <= out_sec;
            o_last       <= out_last;
        end
    end

    `SCC_ASSERT(a_no_overwrite, i_clk, i_rst_n, !(out_load && o_valid && i_stall),
        "result overwritten while stalled")
    `SCC_ASSERT(a_busy, i_clk, i_rst_n, (r_state != ST_IDLE) |-> o_stall,
        "request taken while busy")
    `SCC_ASSERT(a_cnt, i_clk, i_rst_n, r_cnt <= CW'(MaxOut),
        "flush result count overflow")
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector cache clock controller testbench
// Drives read, write, flush and unused requests with random gaps and result
// stalls, predicts every result from a behavioral copy of the tag store and
// clock hand, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import scc_pkg::*;

    localparam int NSLOTS = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        t_func       func;
        logic [2:0]  dev;
        logic [31:0] sec;
        logic [15:0] own;
        int          gap;
        bit          drain;
    } request_t;

    typedef struct {
        logic [5:0]  slot;
        logic        hit;
        logic        fetch;
        logic        wb;
        logic [2:0]  wb_dev;
        logic [31:0] wb_sec;
        logic        last;
    } cache_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_func = 2'd0;
    logic [2:0]  i_device = 3'd0;
    logic [31:0] i_sector = 32'd0;
    logic [15:0] i_owner = 16'd0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid, o_hit, o_fetch, o_write_back, o_last;
    logic [5:0]  o_slot;
    logic [2:0]  o_wb_device;
    logic [31:0] o_wb_sector;

    sector_cache_clock_controller_core dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // behavioral copy of the cache state
    logic [2:0]  tag_dev[NSLOTS];
    logic [31:0] tag_sec[NSLOTS];
    bit          present[NSLOTS];
    bit          used_once[NSLOTS];
    bit          ref_bit[NSLOTS];
    bit          modified[NSLOTS];
    logic [15:0] owner_of[NSLOTS];
    int          hand;

    request_t      pending_q[$];
    cache_result_t expected_q[$];
    int errors, n_hits, n_misses, n_writebacks, n_flushes, n_results;

    task automatic apply_request(input request_t r);
        cache_result_t c;
        int s;
        int i;
        bit found;
        int first;
        c = '{default: '0};
        if (r.func == FUNC_FLUSH) begin
            n_flushes++;
            first = expected_q.size();
            for (i = 0; i < NSLOTS; i++) begin
                if (owner_of[i] != r.own) continue;
                if (modified[i]) begin
                    c = '{slot: i[5:0], hit: 0, fetch: 0, wb: 1, wb_dev: tag_dev[i],
                          wb_sec: tag_sec[i], last: 0};
                    expected_q.push_back(c);
                end
                present[i] = 0; ref_bit[i] = 0; modified[i] = 0; owner_of[i] = '0;
            end
            if (expected_q.size() > first) expected_q[$].last = 1;
            return;
        end
        if (r.func == FUNC_NONE) return;
        found = 0;
        s = 0;
        for (i = 0; i < NSLOTS && !found; i++)
            if (present[i] && tag_dev[i] == r.dev && tag_sec[i] == r.sec) begin
                s = i; found = 1;
            end
        if (found) begin
            c.hit = 1;
            n_hits++;
        end else begin
            n_misses++;
            for (i = 0; i < NSLOTS && !found; i++)
                if (!used_once[i]) begin
                    used_once[i] = 1; s = i; found = 1;
                end
            if (!found) begin
                while (!found) begin
                    hand = (hand + 1) % NSLOTS;
                    if (ref_bit[hand]) ref_bit[hand] = 0;
                    else begin s = hand; found = 1; end
                end
                if (modified[s]) begin
                    c.wb = 1; c.wb_dev = tag_dev[s]; c.wb_sec = tag_sec[s];
                    n_writebacks++;
                end
                present[s] = 0; ref_bit[s] = 0; modified[s] = 0; owner_of[s] = '0;
            end
            tag_dev[s] = r.dev;
            tag_sec[s] = r.sec;
            present[s] = 1;
            c.fetch = 1;
        end
        ref_bit[s] = 1;
        owner_of[s] = r.own;
        if (r.func == FUNC_WRITE) modified[s] = 1;
        c.slot = s[5:0];
        c.last = 1;
        expected_q.push_back(c);
    endtask

    // request driver
    int gap_cnt;
    always @(posedge i_clk) begin
        request_t r;
        bit fire;
        fire = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (fire) apply_request('{func: t_func'(i_func), dev: i_device, sec: i_sector,
                                      own: i_owner, gap: 0, drain: 0});
            if (!i_valid || fire) begin
                if (gap_cnt > 0) begin
                    gap_cnt <= gap_cnt - 1;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             !(pending_q[0].drain && expected_q.size() > 0)) begin
                    r = pending_q.pop_front();
                    i_valid  <= 1'b1;
                    i_func   <= r.func;
                    i_device <= r.dev;
                    i_sector <= r.sec;
                    i_owner  <= r.own;
                    gap_cnt  <= r.gap;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int stall_cnt, hold_cnt;
    bit long_hold_done;

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        cache_result_t e;
        int next_stall;
        next_stall = stall_cnt;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_cnt <= 0;
            hold_cnt <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, slot %0d", $time, o_slot);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("slot", e.slot, o_slot);
                    check_field("hit", e.hit, o_hit);
                    check_field("fetch", e.fetch, o_fetch);
                    check_field("write_back", e.wb, o_write_back);
                    check_field("wb_device", e.wb_dev, o_wb_device);
                    check_field("wb_sector", e.wb_sec, o_wb_sector);
                    check_field("last", e.last, o_last);
                end
                next_stall = (n_results % 120 < 30) ? 0 : $urandom_range(0, 19);
                if (n_results == 150 && !long_hold_done) begin
                    hold_cnt <= 600;
                    long_hold_done <= 1'b1;
                end
            end else if (next_stall > 0) begin
                next_stall--;
            end
            if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
            stall_cnt <= next_stall;
            i_stall <= (next_stall > 0) || (hold_cnt > 1);
        end
    end

    int cycles;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_req(input t_func f, input logic [2:0] d, input logic [31:0] s,
                           input logic [15:0] o, input bit drain = 0);
        int g;
        g = $urandom_range(0, 19);
        pending_q.push_back('{func: f, dev: d, sec: s, own: o, gap: g, drain: drain});
    endtask

    initial begin
        int k;
        int sel;
        t_func f;
        logic [31:0] s;
        logic [15:0] o;
        for (k = 0; k < NSLOTS; k++) begin
            tag_dev[k] = '0; tag_sec[k] = '0; present[k] = 0; used_once[k] = 0;
            ref_bit[k] = 0; modified[k] = 0; owner_of[k] = '0;
        end
        hand = 0;

        // directed: extremes, hits, unused code, flushes
        add_req(FUNC_READ, 3'd0, 32'd0, 16'd0);
        add_req(FUNC_WRITE, 3'd0, 32'd0, 16'd5);
        add_req(FUNC_WRITE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(FUNC_READ, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(FUNC_READ, 3'd5, 32'hAAAA_5555, 16'h5555);
        add_req(FUNC_WRITE, 3'd2, 32'h5555_AAAA, 16'hAAAA);
        add_req(FUNC_NONE, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(FUNC_FLUSH, 3'd0, 32'd0, 16'd9);
        add_req(FUNC_FLUSH, 3'd0, 32'd0, 16'hFFFF);
        add_req(FUNC_FLUSH, 3'd0, 32'd0, 16'd0);
        add_req(FUNC_READ, 3'd7, 32'hFFFF_FFFF, 16'd1);
        add_req(FUNC_FLUSH, 3'd0, 32'd0, 16'd5, 1);
        add_req(FUNC_READ, 3'd0, 32'd0, 16'd0);

        // random: small sector pool so hits, clock walks and write-backs all occur
        for (k = 0; k < 420; k++) begin
            sel = $urandom_range(0, 99);
            f = sel < 42 ? FUNC_READ : sel < 84 ? FUNC_WRITE : sel < 97 ? FUNC_FLUSH : FUNC_NONE;
            s = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 90);
            o = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
            add_req(f, ($urandom_range(0, 3) == 0) ? 3'($urandom()) : 3'd1, s, o, k == 200);
            if (k >= 120 && k < 180) pending_q[$].gap = 0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0 && !i_valid && expected_q.size() == 0);
        repeat (400) @(posedge i_clk);
        if (expected_q.size() != 0) errors++;
        $display("Covered %0d hits, %0d misses, %0d victim write-backs, %0d flushes;",
                 n_hits, n_misses, n_writebacks, n_flushes);
        $display("%0d results checked, %0d mismatches.", n_results, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
